// File: rtl/quaternion_multiply_rotate_macros.svh
// Assertion helpers used by the checker file.
`ifndef QUATERNION_MULTIPLY_ROTATE_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define QMR_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## (dly) (cons)) \
    else $error(msg);

`endif

// File: rtl/qmr_pkg.sv
package qmr_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // first-pass rounded result, kept unsaturated for the rotation
  localparam int T_W    = 2 * COMP_WIDTH + 2 - FRAC_BITS;
  localparam int PROD_W = T_W + COMP_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - FRAC_BITS;

  // accept edge to the edge at which the result transfers
  localparam int LATENCY = 5;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [T_W-1:0]        wide_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [RND_W-1:0]      rnd_t;

  typedef enum logic {
    CMD_MUL = 1'b0,
    CMD_ROT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } ctl_t;

  // component order w, x, y, z
  localparam logic [1:0] IDX_W = 2'd0;

  localparam comp_t ONE     = comp_t'(1) <<< FRAC_BITS;
  localparam comp_t SAT_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t SAT_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  // Hamilton product terms: result component c, term t
  localparam logic [1:0] TERM_A [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] TERM_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic TERM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1}
  };

endpackage

// File: rtl/quaternion_multiply_rotate.sv
// Quaternion Hamilton product and vector rotation, signed Q2.14 components.
// Input: drive start high with in_cmd and the A and B components; the item
// transfers at the rising edge where start is high and busy is low. busy
// stays low, so a new item may transfer in every cycle.
// in_cmd = product: result is A*B. in_cmd = rotate: result is the vector
// (in_b_x, in_b_y, in_b_z) rotated by A as A*v*conj(A), with out_res_w = 0.
// Output: out_valid is high for exactly one cycle per item, carrying the
// four components and out_clipped (set when any returned component hit the
// signed range limit). The receiver cannot stall; results must be taken.
// Throughput: one item per cycle. Two passes of the same four-by-four
// multiply and round pipe set the depth: the first forms A*B (or A*v), the
// second multiplies by conj(A), or by one for a plain product.
// Reset (rst_n low, synchronous) clears all valid bits; items in flight
// are dropped and no result appears for them.
module quaternion_multiply_rotate import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  logic  in_cmd,
  input  comp_t in_a_w,
  input  comp_t in_a_x,
  input  comp_t in_a_y,
  input  comp_t in_a_z,
  input  comp_t in_b_w,
  input  comp_t in_b_x,
  input  comp_t in_b_y,
  input  comp_t in_b_z,
  output logic  out_valid,
  output comp_t out_res_w,
  output comp_t out_res_x,
  output comp_t out_res_y,
  output comp_t out_res_z,
  output logic  out_clipped
);

  ctl_t  ctl_in;
  ctl_t  ctl_mid;
  ctl_t  ctl_fin;
  wide_t p1 [4];
  comp_t q1 [4];
  rnd_t  r1 [4];
  wide_t p2 [4];
  comp_t q2 [4];
  rnd_t  r2 [4];
  comp_t a_in [4];
  comp_t a_d1_r [4];
  comp_t a_d2_r [4];
  comp_t res [4];

  assign busy = 1'b0;

  assign ctl_in.vld = start && !busy;
  assign ctl_in.cmd = cmd_t'(in_cmd);

  assign a_in[0] = in_a_w;
  assign a_in[1] = in_a_x;
  assign a_in[2] = in_a_y;
  assign a_in[3] = in_a_z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p1[i] = wide_t'(a_in[i]);
    end
    q1[0] = (ctl_in.cmd == CMD_ROT) ? '0 : in_b_w;
    q1[1] = in_b_x;
    q1[2] = in_b_y;
    q1[3] = in_b_z;
  end

  qmr_qmul u_pass1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_in),
    .p_in    (p1),
    .q_in    (q1),
    .conj_q  (1'b0),
    .ctl_out (ctl_mid),
    .r_out   (r1)
  );

  // hold A alongside the first pass
  always_ff @(posedge clk) begin
    a_d1_r <= a_in;
    a_d2_r <= a_d1_r;
  end

  // plain product passes through unchanged: multiply by one
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p2[i] = wide_t'(r1[i]);
      if (ctl_mid.cmd == CMD_ROT) begin
        q2[i] = a_d2_r[i];
      end else begin
        q2[i] = (i == 0) ? ONE : '0;
      end
    end
  end

  qmr_qmul u_pass2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_mid),
    .p_in    (p2),
    .q_in    (q2),
    .conj_q  (1'b1),
    .ctl_out (ctl_fin),
    .r_out   (r2)
  );

  qmr_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_fin),
    .r_in      (r2),
    .out_valid (out_valid),
    .res_out   (res),
    .clipped   (out_clipped)
  );

  assign out_res_w = res[0];
  assign out_res_x = res[1];
  assign out_res_y = res[2];
  assign out_res_z = res[3];

endmodule

// File: rtl/qmr_qmul.sv
module qmr_qmul import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl_in,
  input  wide_t p_in [4],
  input  comp_t q_in [4],
  input  logic  conj_q,
  output ctl_t  ctl_out,
  output rnd_t  r_out [4]
);

  ctl_t  ctl1_r;
  ctl_t  ctl2_r;
  prod_t prod_r   [4][4];
  prod_t prod_nxt [4][4];
  rnd_t  r_r   [4];
  rnd_t  r_nxt [4];

  // stage 1: sixteen products, sign folded in (conjugate negates the vector part of q)
  always_comb begin
    prod_t m;
    logic  neg;
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        m   = prod_t'(p_in[TERM_A[c][t]]) * prod_t'(q_in[TERM_B[c][t]]);
        neg = TERM_NEG[c][t] ^ (conj_q && (TERM_B[c][t] != IDX_W));
        prod_nxt[c][t] = neg ? -m : m;
      end
    end
  end

  // stage 2: sum of four, add half an LSB, shift
  always_comb begin
    acc_t acc;
    for (int c = 0; c < 4; c++) begin
      acc = acc_t'(1) <<< (FRAC_BITS - 1);
      for (int t = 0; t < 4; t++) begin
        acc = acc + acc_t'(prod_r[c][t]);
      end
      r_nxt[c] = rnd_t'(acc >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    r_r    <= r_nxt;
  end

  assign ctl_out = ctl2_r;
  assign r_out   = r_r;

endmodule

// File: rtl/qmr_sat.sv
module qmr_sat import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl_in,
  input  rnd_t  r_in [4],
  output logic  out_valid,
  output comp_t res_out [4],
  output logic  clipped
);

  logic  out_valid_r;
  comp_t res_r   [4];
  comp_t res_nxt [4];
  logic  clip_r;
  logic  clip_nxt;

  always_comb begin
    logic hi;
    logic lo;
    clip_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      hi = r_in[i] > rnd_t'(SAT_MAX);
      lo = r_in[i] < rnd_t'(SAT_MIN);
      if (hi) begin
        res_nxt[i] = SAT_MAX;
      end else if (lo) begin
        res_nxt[i] = SAT_MIN;
      end else begin
        res_nxt[i] = comp_t'(r_in[i]);
      end
      // rotation drops the scalar part
      if (ctl_in.cmd == CMD_ROT && i == 0) begin
        res_nxt[i] = '0;
      end else begin
        clip_nxt = clip_nxt | hi | lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    clip_r <= clip_nxt;
  end

  assign out_valid = out_valid_r;
  assign res_out   = res_r;
  assign clipped   = clip_r;

endmodule

// File: rtl/qmr_chk.sv
`include "quaternion_multiply_rotate_macros.svh"

module qmr_chk import qmr_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  start,
  input logic  busy,
  input logic  in_cmd,
  input comp_t in_a_w,
  input comp_t in_a_x,
  input comp_t in_a_y,
  input comp_t in_a_z,
  input comp_t in_b_w,
  input comp_t in_b_x,
  input comp_t in_b_y,
  input comp_t in_b_z,
  input logic  out_valid,
  input comp_t out_res_w,
  input comp_t out_res_x,
  input comp_t out_res_y,
  input comp_t out_res_z,
  input logic  out_clipped
);

  // every transfer in gives one result a fixed time later
  `QMR_ASSERT_DLY(a_lat, start && !busy, LATENCY, out_valid, "result missing after transfer")

  // no result without a matching transfer in
  `QMR_ASSERT_IMP(a_src, out_valid, $past(start && !busy, LATENCY), "result without transfer")

  // rotation returns a zero scalar part
  `QMR_ASSERT_IMP(a_rot_w, out_valid && $past(start && in_cmd, LATENCY), out_res_w == '0, "rotation scalar not zero")

  // identity times B gives B exactly
  `QMR_ASSERT_IMP(a_ident, out_valid && $past(start && !in_cmd && in_a_w == ONE && in_a_x == '0 && in_a_y == '0 && in_a_z == '0, LATENCY), !out_clipped && out_res_w == $past(in_b_w, LATENCY) && out_res_x == $past(in_b_x, LATENCY) && out_res_y == $past(in_b_y, LATENCY) && out_res_z == $past(in_b_z, LATENCY), "identity product differs from B")

endmodule

bind quaternion_multiply_rotate qmr_chk u_qmr_chk (.*);

// File: tb/tb_quaternion_multiply_rotate.sv
`timescale 1ns / 1ps

module tb_quaternion_multiply_rotate;
  import qmr_pkg::*;

  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 1650;
  localparam int IDLE_LIMIT = 200;

  typedef struct packed {
    cmd_t  cmd;
    comp_t a_w, a_x, a_y, a_z;
    comp_t b_w, b_x, b_y, b_z;
  } quat_op_t;

  typedef struct packed {
    comp_t w, x, y, z;
    logic  clipped;
  } quat_res_t;

  typedef struct {
    quat_op_t  op;
    bit        typed;
    quat_res_t want;
  } dir_row_t;

  typedef struct {
    longint w, x, y, z;
  } wide_quat_t;

  typedef enum {MAG_FULL, MAG_UNIT_BOX, MAG_CORNER, MAG_HALF} mag_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  quat_op_t  drive_op = '0;
  bit        row_typed = 1'b0;
  quat_res_t row_want = '0;

  logic      out_valid;
  comp_t     out_res_w, out_res_x, out_res_y, out_res_z;
  logic      out_clipped;

  quat_res_t pending_quats[$];
  quat_res_t want_res;
  dir_row_t  dir_rows[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;

  always #4 clk = ~clk;

  quaternion_multiply_rotate u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (drive_op.cmd),
    .in_a_w     (drive_op.a_w),
    .in_a_x     (drive_op.a_x),
    .in_a_y     (drive_op.a_y),
    .in_a_z     (drive_op.a_z),
    .in_b_w     (drive_op.b_w),
    .in_b_x     (drive_op.b_x),
    .in_b_y     (drive_op.b_y),
    .in_b_z     (drive_op.b_z),
    .out_valid  (out_valid),
    .out_res_w  (out_res_w),
    .out_res_x  (out_res_x),
    .out_res_y  (out_res_y),
    .out_res_z  (out_res_z),
    .out_clipped(out_clipped)
  );

  // add half an LSB, then drop the fraction bits (ties go up)
  function automatic longint round_frac(longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic wide_quat_t hamilton(wide_quat_t p, wide_quat_t q);
    wide_quat_t r;
    r.w = round_frac(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z);
    r.x = round_frac(p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y);
    r.y = round_frac(p.w * q.y + p.y * q.w + p.z * q.x - p.x * q.z);
    r.z = round_frac(p.w * q.z + p.z * q.w + p.x * q.y - p.y * q.x);
    return r;
  endfunction

  function automatic comp_t clamp_comp(input longint v, inout logic hit);
    if (v > longint'(SAT_MAX)) begin
      hit = 1'b1;
      return SAT_MAX;
    end
    if (v < longint'(SAT_MIN)) begin
      hit = 1'b1;
      return SAT_MIN;
    end
    return comp_t'(v);
  endfunction

  function automatic quat_res_t quat_op_result(quat_op_t op);
    wide_quat_t a, b, cj, r;
    quat_res_t  res;
    logic       hit;
    hit = 1'b0;
    a = '{op.a_w, op.a_x, op.a_y, op.a_z};
    if (op.cmd == CMD_MUL) begin
      b = '{op.b_w, op.b_x, op.b_y, op.b_z};
      r = hamilton(a, b);
      res.w = clamp_comp(r.w, hit);
    end else begin
      // the first pass stays unsaturated; b_w takes no part
      b = '{0, op.b_x, op.b_y, op.b_z};
      cj = '{a.w, -a.x, -a.y, -a.z};
      r = hamilton(hamilton(a, b), cj);
      res.w = '0;
    end
    res.x = clamp_comp(r.x, hit);
    res.y = clamp_comp(r.y, hit);
    res.z = clamp_comp(r.z, hit);
    res.clipped = hit;
    return res;
  endfunction

  function automatic comp_t pick_comp(mag_t mag);
    case (mag)
      MAG_FULL:     return comp_t'($urandom);
      MAG_UNIT_BOX: return comp_t'(int'($urandom_range(0, 2 * ONE_I)) - ONE_I);
      MAG_CORNER: begin
        case ($urandom_range(0, 6))
          0:       return SAT_MIN;
          1:       return SAT_MAX;
          2:       return ONE;
          3:       return -ONE;
          4:       return comp_t'(1);
          5:       return comp_t'(-1);
          default: return '0;
        endcase
      end
      default: begin
        // about one half, so a quaternion of four such parts is near unit
        return comp_t'(($urandom_range(0, 1) ? ONE_I / 2 : -ONE_I / 2)
                       + int'($urandom_range(0, 64)) - 32);
      end
    endcase
  endfunction

  function automatic quat_op_t rand_op();
    quat_op_t op;
    mag_t     ma, mb;
    op.cmd = cmd_t'($urandom_range(0, 1));
    ma = mag_t'($urandom_range(0, 3));
    mb = mag_t'($urandom_range(0, 3));
    if (op.cmd == CMD_ROT && $urandom_range(0, 3) != 0)
      ma = MAG_HALF;
    op.a_w = pick_comp(ma);
    op.a_x = pick_comp(ma);
    op.a_y = pick_comp(ma);
    op.a_z = pick_comp(ma);
    op.b_w = pick_comp(mb);
    op.b_x = pick_comp(mb);
    op.b_y = pick_comp(mb);
    op.b_z = pick_comp(mb);
    return op;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // drive one item and hold it until it transfers
  task automatic send_op(quat_op_t op, bit typed, quat_res_t want);
    start <= 1'b1;
    drive_op <= op;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // step at least one edge so the last transfer is queued before checking
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_quats.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid) begin
        if (pending_quats.size() == 0) begin
          flag_mismatch("result with nothing outstanding");
        end else begin
          want_res = pending_quats.pop_front();
          if (out_res_w !== want_res.w)
            flag_mismatch($sformatf("res_w got %0d want %0d", out_res_w, want_res.w));
          if (out_res_x !== want_res.x)
            flag_mismatch($sformatf("res_x got %0d want %0d", out_res_x, want_res.x));
          if (out_res_y !== want_res.y)
            flag_mismatch($sformatf("res_y got %0d want %0d", out_res_y, want_res.y));
          if (out_res_z !== want_res.z)
            flag_mismatch($sformatf("res_z got %0d want %0d", out_res_z, want_res.z));
          if (out_clipped !== want_res.clipped)
            flag_mismatch($sformatf("clipped got %0b want %0b", out_clipped,
                                    want_res.clipped));
        end
      end
      if (start && !busy)
        pending_quats.push_back(row_typed ? row_want : quat_op_result(drive_op));
      idle_cycles <= (out_valid || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("quaternion_multiply_rotate: mismatch");
    $finish;
  end

  initial begin
    int burst_left;

    dir_rows.push_back('{'{CMD_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0}, 1'b1,
                         '{ONE, 0, 0, 0, 1'b0}});
    dir_rows.push_back('{'{CMD_MUL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                           SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN}, 1'b1,
                         '{SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1}});
    dir_rows.push_back('{'{CMD_MUL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                           SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX}, 1'b1,
                         '{SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1}});
    dir_rows.push_back('{'{CMD_MUL, 0, 0, 0, 0, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN},
                         1'b1, '{0, 0, 0, 0, 1'b0}});
    dir_rows.push_back('{'{CMD_MUL, ONE, 0, 0, 0, 16'sd1234, -16'sd5678, 16'sd9, SAT_MIN},
                         1'b1, '{16'sd1234, -16'sd5678, 16'sd9, SAT_MIN, 1'b0}});
    // i*i = -1 and i*j = k
    dir_rows.push_back('{'{CMD_MUL, 0, ONE, 0, 0, 0, ONE, 0, 0}, 1'b1,
                         '{-ONE, 0, 0, 0, 1'b0}});
    dir_rows.push_back('{'{CMD_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0}, 1'b1,
                         '{0, 0, 0, ONE, 1'b0}});
    // exact half LSB rounds up on both signs
    dir_rows.push_back('{'{CMD_MUL, 16'sd1, 0, 0, 0, 16'sd8192, 0, 0, 0}, 1'b1,
                         '{16'sd1, 0, 0, 0, 1'b0}});
    dir_rows.push_back('{'{CMD_MUL, -16'sd1, 0, 0, 0, 16'sd8192, 0, 0, 0}, 1'b1,
                         '{0, 0, 0, 0, 1'b0}});
    dir_rows.push_back('{'{CMD_MUL, SAT_MIN, 0, 0, 0, SAT_MIN, 0, 0, 0}, 1'b1,
                         '{SAT_MAX, 0, 0, 0, 1'b1}});
    dir_rows.push_back('{'{CMD_MUL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                           SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN}, 1'b0, '0});
    dir_rows.push_back('{'{CMD_MUL, 16'sd12345, -16'sd23456, SAT_MAX, SAT_MIN,
                           -16'sd1, 16'sd2, -16'sd3, 16'sd4}, 1'b0, '0});
    dir_rows.push_back('{'{CMD_MUL, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                           16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0});
    // identity rotation leaves the vector alone and ignores b_w
    dir_rows.push_back('{'{CMD_ROT, ONE, 0, 0, 0, 16'sd777, SAT_MIN, SAT_MAX, 16'sd1234},
                         1'b1, '{0, SAT_MIN, SAT_MAX, 16'sd1234, 1'b0}});
    dir_rows.push_back('{'{CMD_ROT, 0, 0, 0, 0, SAT_MAX, SAT_MAX, SAT_MIN, -16'sd1},
                         1'b1, '{0, 0, 0, 0, 1'b0}});
    // non-unit A scales by |A|^2 and saturates
    dir_rows.push_back('{'{CMD_ROT, SAT_MIN, 0, 0, 0, 0, ONE, 0, 0}, 1'b1,
                         '{0, SAT_MAX, 0, 0, 1'b1}});
    // half turn about z
    dir_rows.push_back('{'{CMD_ROT, 0, 0, 0, ONE, 0, ONE, 0, 0}, 1'b1,
                         '{0, -ONE, 0, 0, 1'b0}});
    dir_rows.push_back('{'{CMD_ROT, 16'sd11585, 0, 0, 16'sd11585, 0, ONE, 16'sd8192, 0},
                         1'b0, '0});
    dir_rows.push_back('{'{CMD_ROT, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192,
                           0, SAT_MAX, SAT_MIN, SAT_MAX}, 1'b0, '0});
    dir_rows.push_back('{'{CMD_ROT, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                           SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN}, 1'b0, '0});
    dir_rows.push_back('{'{CMD_ROT, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                           SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN}, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 1) != 0)
        idle_for($urandom_range(1, 3));
    end
    drain_results();

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        if ($urandom_range(0, 3) != 0)
          idle_for($urandom_range(1, 10));
      end
      if (i == RANDOM_ITEMS / 2)
        drain_results();
      send_op(rand_op(), 1'b0, '0);
      burst_left--;
    end

    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0)
      $display("quaternion_multiply_rotate: match");
    else
      $display("quaternion_multiply_rotate: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/qmr_pkg.sv
rtl/qmr_qmul.sv
rtl/qmr_sat.sv
rtl/quaternion_multiply_rotate.sv
rtl/qmr_chk.sv
tb/tb_quaternion_multiply_rotate.sv
